// ----- hw/rtl/pval_pkg.sv -----
// Shared types and constants for the pair voice admission limiter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pval_pkg;

    localparam int NUM_NODES   = 32;
    localparam int NODE_W      = 6;
    localparam int AMOUNT_W    = 11;
    localparam int ROW_W       = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_COUNT    = 2'd0,
        KIND_SENDER   = 2'd1,
        KIND_RECEIVER = 2'd2,
        KIND_OVF      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_NOTE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_BAD   = 2'd2
    } op_t;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] receiver;
        logic              note_on;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [AMOUNT_W-1:0] amount;
        logic [NODE_W-1:0]   ovf_sender;
        logic [NODE_W-1:0]   ovf_receiver;
        logic                ovf_on;
        logic                last;
    } result_t;

    // Classified item as it travels from the front end to the back end.
    typedef struct packed {
        op_t               op;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] receiver;
        logic              note_on;
    } cls_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pval_front.sv -----
// Front end: accepts command transfers and classifies them for the back end.
// Depends on pval_pkg.
`default_nettype none

module pval_front (
    input  wire logic            start,
    input  wire pval_pkg::item_t item,
    input  wire logic            q_full,
    output logic                 busy,
    output logic                 push,
    output pval_pkg::cls_t       entry
);
    import pval_pkg::*;

    logic s_ok;
    logic r_ok;

    assign s_ok = (item.sender != '0) && (int'(item.sender) <= NUM_NODES);
    assign r_ok = (item.receiver != '0) && (int'(item.receiver) <= NUM_NODES);

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        entry.sender   = item.sender;
        entry.receiver = item.receiver;
        entry.note_on  = item.note_on;
        entry.col      = ROW_W'(item.sender - NODE_W'(1));
        entry.row      = ROW_W'(item.receiver - NODE_W'(1));
        if (item.cmd)
        begin
            entry.op = OP_CLEAR;
        end
        else if (s_ok && r_ok)
        begin
            entry.op = OP_NOTE;
        end
        else
        begin
            entry.op = OP_BAD;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pval_queue.sv -----
// Short queue of classified items between the front end and the back end.
// Depends on pval_pkg.
`default_nettype none

module pval_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pval_pkg::cls_t push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output pval_pkg::cls_t      head
);
    import pval_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (int'(cnt_reg) == QUEUE_DEPTH);
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill level stays within the queue and moves by at most one a cycle.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= QUEUE_DEPTH)
        else $error("queue fill level beyond depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CNT_W'(1))
        || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("queue fill level moved by more than one");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer offered to a full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop requested from an empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/pval_back.sv -----
// Back end: holds the pair map and the active count and produces results.
// Depends on pval_pkg.
`default_nettype none

module pval_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire pval_pkg::cls_t                q_head,
    input  wire logic [pval_pkg::AMOUNT_W-1:0] max_voices,
    output logic                               q_pop,
    output logic                               result_valid,
    output pval_pkg::result_t                  result
);
    import pval_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SECOND
    } state_t;

    logic [NUM_NODES-1:0] mem [NUM_NODES];

    state_t               state_reg;
    state_t               state_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    result_t              res_reg;
    result_t              res_next;
    result_t              sec_reg;
    result_t              sec_next;
    logic [AMOUNT_W-1:0]  count_reg;
    logic [AMOUNT_W-1:0]  count_next;
    logic [NUM_NODES-1:0] row_valid_reg;
    logic [NUM_NODES-1:0] row_valid_next;
    logic                 fwd_valid_reg;
    logic                 fwd_valid_next;
    logic [ROW_W-1:0]     fwd_row_reg;
    logic [NUM_NODES-1:0] fwd_data_reg;
    cls_t                 cur_reg;
    logic [NUM_NODES-1:0] mem_q_reg;
    logic                 rv_q_reg;

    logic                 eval;
    logic                 emit;
    logic                 two;
    logic                 wr_en;
    logic                 clr;
    logic                 take;
    logic [NUM_NODES-1:0] eff_row;
    logic [NUM_NODES-1:0] new_row;
    logic                 hit;
    logic [AMOUNT_W-1:0]  cap;
    logic [AMOUNT_W-1:0]  dec;
    result_t              first;

    assign eval = (state_reg == ST_EVAL);
    assign cap  = (max_voices == '0) ? AMOUNT_W'(1) : max_voices;
    assign eff_row = (fwd_valid_reg && (fwd_row_reg == cur_reg.row)) ? fwd_data_reg
                   : (rv_q_reg ? mem_q_reg : '0);
    assign hit  = eff_row[cur_reg.col];
    assign dec  = (count_reg != '0) ? count_reg - AMOUNT_W'(1) : count_reg;

    always_comb
    begin
        first      = '0;
        first.kind = KIND_COUNT;
        sec_next   = '0;
        sec_next.kind = KIND_COUNT;
        sec_next.last = 1'b1;
        emit       = 1'b0;
        two        = 1'b0;
        wr_en      = 1'b0;
        clr        = 1'b0;
        new_row    = eff_row;
        count_next = count_reg;
        case (cur_reg.op)
            OP_CLEAR:
            begin
                clr        = 1'b1;
                emit       = 1'b1;
                count_next = '0;
                first.last = 1'b1;
            end
            OP_NOTE:
            begin
                if (cur_reg.note_on)
                begin
                    if (hit)
                    begin
                        emit = 1'b0;
                    end
                    else if (count_reg < cap)
                    begin
                        emit                 = 1'b1;
                        two                  = 1'b1;
                        wr_en                = 1'b1;
                        new_row[cur_reg.col] = 1'b1;
                        count_next           = count_reg + AMOUNT_W'(1);
                        first.amount         = count_next;
                        sec_next.kind        = KIND_RECEIVER;
                        sec_next.amount      = AMOUNT_W'(cur_reg.receiver);
                    end
                    else
                    begin
                        emit               = 1'b1;
                        first.kind         = KIND_OVF;
                        first.ovf_sender   = cur_reg.sender;
                        first.ovf_receiver = cur_reg.receiver;
                        first.ovf_on       = 1'b1;
                        first.last         = 1'b1;
                    end
                end
                else if (hit)
                begin
                    emit                 = 1'b1;
                    wr_en                = 1'b1;
                    new_row[cur_reg.col] = 1'b0;
                    count_next           = dec;
                    first.amount         = dec;
                    if (dec < cap)
                    begin
                        two             = 1'b1;
                        sec_next.kind   = KIND_SENDER;
                        sec_next.amount = AMOUNT_W'(cur_reg.sender);
                    end
                    else
                    begin
                        first.last = 1'b1;
                    end
                end
                else
                begin
                    emit               = 1'b1;
                    first.kind         = KIND_OVF;
                    first.ovf_sender   = cur_reg.sender;
                    first.ovf_receiver = cur_reg.receiver;
                    first.last         = 1'b1;
                end
            end
            default:
            begin
                emit               = 1'b1;
                first.kind         = KIND_OVF;
                first.ovf_sender   = cur_reg.sender;
                first.ovf_receiver = cur_reg.receiver;
                first.ovf_on       = cur_reg.note_on;
                first.last         = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        take           = (state_reg == ST_IDLE) || (state_reg == ST_SECOND) || (eval && !two);
        q_pop          = take && q_valid;
        state_next     = q_pop ? ST_EVAL : ST_IDLE;
        res_valid_next = 1'b0;
        res_next       = sec_reg;
        row_valid_next = row_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        if (eval)
        begin
            res_valid_next = emit;
            res_next       = first;
            if (two)
            begin
                state_next = ST_SECOND;
            end
            if (clr)
            begin
                row_valid_next = '0;
                fwd_valid_next = 1'b0;
            end
            else if (wr_en)
            begin
                row_valid_next[cur_reg.row] = 1'b1;
                fwd_valid_next              = 1'b1;
            end
        end
        else if (state_reg == ST_SECOND)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            row_valid_reg <= row_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            if (eval)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (eval)
        begin
            sec_reg <= sec_next;
        end
        if (eval && wr_en)
        begin
            fwd_row_reg  <= cur_reg.row;
            fwd_data_reg <= new_row;
        end
        if (q_pop)
        begin
            cur_reg  <= q_head;
            rv_q_reg <= row_valid_next[q_head.row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval && wr_en)
        begin
            mem[cur_reg.row] <= new_row;
        end
        if (q_pop)
        begin
            mem_q_reg <= mem[q_head.row];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_second_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SECOND) |-> $past(state_reg == ST_EVAL))
        else $error("second result without an evaluation before it");

    a_ovf_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_OVF)) |-> result.last)
        else $error("overflow record not marked last");

    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SECOND) |=> (result_valid && result.last))
        else $error("second result missing or not marked last");

endmodule

`default_nettype wire

// ----- hw/rtl/pair_voice_admission_limiter_core.sv -----
// Top level of the pair voice admission limiter: front end, queue and back end.
// Depends on pval_pkg, pval_front, pval_queue and pval_back.
//
//   Channel   Signals                          Transfer when
//   command   start, busy, item                start high and busy low
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//   result    result_valid, result             result_valid high (one cycle)
//
// An item accepted into the queue is popped into the back end's current-item register
// once the back end can take it, is evaluated there, and its first result is registered
// onto the result ports; a second result follows in the next cycle.
// The back end takes a new item every cycle when an item gives at most one result; an
// item that gives two holds off the next one, set by the single result port.
// Reset clears the map, the count and the queue at once; there is no clearing pass.
// Results cannot be held off; busy rises only while the two-entry queue is full.
`default_nettype none

module pair_voice_admission_limiter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pval_pkg::item_t               item,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pval_pkg::AMOUNT_W-1:0] cfg_data,
    output logic                               result_valid,
    output pval_pkg::result_t                  result
);
    import pval_pkg::*;

    logic                cfg_write;
    logic [AMOUNT_W-1:0] max_voices_reg;
    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    cls_t                entry;
    cls_t                head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_voices_reg <= AMOUNT_W'(1);
        end
        else if (cfg_write)
        begin
            max_voices_reg <= cfg_data;
        end
    end

    pval_front u_front (
        .start  (start),
        .item   (item),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .entry  (entry)
    );

    pval_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    pval_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (head),
        .max_voices   (max_voices_reg),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- sim/tb_pair_voice_admission_limiter_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pair_voice_admission_limiter_core, with its scoreboard class.
// Depends on pval_pkg and the block's RTL. A directed part is followed by random phases
// at several voice caps; results are checked field by field against an internal predictor.

module tb_pair_voice_admission_limiter_core;

    import pval_pkg::*;

    localparam logic CMD_NOTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam int   PAIRS     = NUM_NODES * NUM_NODES;
    localparam int   SETTLE    = 10;
    localparam int   LIMIT     = 200000;

    class pair_map_scoreboard;
        bit                  active [PAIRS];
        int unsigned         count;
        logic [AMOUNT_W-1:0] max_voices;
        result_t             expected [$];
        int unsigned         errors;
        int unsigned         items;
        int unsigned         results;
        int unsigned         overflows;
        int unsigned         peak;

        function new();
            foreach (active[i]) active[i] = 1'b0;
            count      = 0;
            max_voices = 1;
            errors     = 0;
            items      = 0;
            results    = 0;
            overflows  = 0;
            peak       = 0;
        endfunction

        function void set_cap(logic [AMOUNT_W-1:0] value);
            max_voices = value;
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        function void push(kind_t k, int unsigned amt, logic [NODE_W-1:0] s,
                           logic [NODE_W-1:0] r, logic on, logic fin);
            result_t res;
            res.kind         = k;
            res.amount       = amt[AMOUNT_W-1:0];
            res.ovf_sender   = s;
            res.ovf_receiver = r;
            res.ovf_on       = on;
            res.last         = fin;
            expected.push_back(res);
        endfunction

        function bit pick_active(output logic [NODE_W-1:0] s, output logic [NODE_W-1:0] r);
            int unsigned first;
            int unsigned idx;
            s = '0;
            r = '0;
            if (count == 0)
                return 1'b0;
            first = $urandom_range(0, PAIRS - 1);
            for (int unsigned n = 0; n < PAIRS; n++) begin
                idx = (first + n) % PAIRS;
                if (active[idx]) begin
                    s = NODE_W'(idx % NUM_NODES + 1);
                    r = NODE_W'(idx / NUM_NODES + 1);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note(item_t it);
            int unsigned cap;
            int unsigned idx;
            bit          in_range;
            cap = (max_voices == 0) ? 1 : int'(max_voices);
            items++;
            if (it.cmd == CMD_CLEAR) begin
                foreach (active[i]) active[i] = 1'b0;
                count = 0;
                push(KIND_COUNT, 0, '0, '0, 1'b0, 1'b1);
                return;
            end
            in_range = int'(it.sender) >= 1 && int'(it.sender) <= NUM_NODES
                       && int'(it.receiver) >= 1 && int'(it.receiver) <= NUM_NODES;
            idx = in_range ? (int'(it.sender) - 1) + (int'(it.receiver) - 1) * NUM_NODES : 0;
            if (it.note_on) begin
                if (in_range && active[idx])
                    return;
                if (in_range && count < cap) begin
                    active[idx] = 1'b1;
                    count++;
                    if (count > peak)
                        peak = count;
                    push(KIND_COUNT, count, '0, '0, 1'b0, 1'b0);
                    push(KIND_RECEIVER, int'(it.receiver), '0, '0, 1'b0, 1'b1);
                    return;
                end
                push(KIND_OVF, 0, it.sender, it.receiver, 1'b1, 1'b1);
                return;
            end
            if (in_range && active[idx]) begin
                active[idx] = 1'b0;
                if (count > 0)
                    count--;
                if (count < cap) begin
                    push(KIND_COUNT, count, '0, '0, 1'b0, 1'b0);
                    push(KIND_SENDER, int'(it.sender), '0, '0, 1'b0, 1'b1);
                end
                else begin
                    push(KIND_COUNT, count, '0, '0, 1'b0, 1'b1);
                end
                return;
            end
            push(KIND_OVF, 0, it.sender, it.receiver, 1'b0, 1'b1);
        endfunction

        function void check(result_t got);
            result_t want;
            results++;
            if (expected.size() == 0) begin
                $error("unexpected result: kind %0d amount %0d", got.kind, got.amount);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.kind == KIND_OVF)
                overflows++;
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.amount !== want.amount) begin
                $error("amount: expected %0d, got %0d", want.amount, got.amount);
                errors++;
            end
            if (got.ovf_sender !== want.ovf_sender) begin
                $error("ovf_sender: expected %0d, got %0d", want.ovf_sender, got.ovf_sender);
                errors++;
            end
            if (got.ovf_receiver !== want.ovf_receiver) begin
                $error("ovf_receiver: expected %0d, got %0d",
                       want.ovf_receiver, got.ovf_receiver);
                errors++;
            end
            if (got.ovf_on !== want.ovf_on) begin
                $error("ovf_on: expected %0d, got %0d", want.ovf_on, got.ovf_on);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    item_t               item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [AMOUNT_W-1:0] cfg_data;
    logic                result_valid;
    result_t             result;

    pair_map_scoreboard  sb;
    int unsigned         cycles;
    int unsigned         burst;
    int unsigned         cap_writes;

    pair_voice_admission_limiter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check(result);
    end

    function automatic int unsigned next_gap();
        int unsigned roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [NODE_W-1:0] rand_node(bit narrow);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return (roll < 3) ? NODE_W'(0) : NODE_W'($urandom_range(NUM_NODES + 1, 63));
        if (narrow && roll < 85)
            return NODE_W'($urandom_range(1, 4));
        return NODE_W'($urandom_range(1, NUM_NODES));
    endfunction

    function automatic item_t make_item(logic cmd, int unsigned s, int unsigned r, logic on);
        item_t it;
        it.cmd      = cmd;
        it.sender   = NODE_W'(s);
        it.receiver = NODE_W'(r);
        it.note_on  = on;
        return it;
    endfunction

    task automatic send_item(item_t it, int unsigned gap);
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(it);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cap(logic [AMOUNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_cap(value);
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int unsigned n, int unsigned on_pct, bit narrow);
        item_t             it;
        logic [NODE_W-1:0] s;
        logic [NODE_W-1:0] r;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                it = make_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                               1'($urandom_range(0, 1)));
            end
            else begin
                it = make_item(CMD_NOTE, 0, 0, $urandom_range(0, 99) < on_pct);
                if (!(!it.note_on && $urandom_range(0, 99) < 60 && sb.pick_active(s, r))) begin
                    s = rand_node(narrow);
                    r = rand_node(narrow);
                end
                it.sender   = s;
                it.receiver = r;
            end
            send_item(it, next_gap());
        end
        drain();
    endtask

    initial
    begin
        sb         = new();
        cycles     = 0;
        burst      = 0;
        cap_writes = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset cap of one: overflow, admission, repeats, out-of-range nodes and clears.
        send_item(make_item(CMD_NOTE, 1, 1, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 1, 1, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 1, 1, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 2, 3, 1'b1), 1);
        send_item(make_item(CMD_NOTE, 1, 1, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 32, 32, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 32, 32, 1'b0), 2);
        send_item(make_item(CMD_NOTE, 0, 5, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 5, 0, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 63, 63, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 33, 1, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 1, 40, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 1, 32, 1'b1), 0);
        send_item(make_item(CMD_CLEAR, 63, 63, 1'b1), 0);
        send_item(make_item(CMD_CLEAR, 0, 0, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 1, 32, 1'b0), 0);
        drain();

        // Cap lowered below the active count, then a cap of zero acting as one.
        write_cap(3);
        send_item(make_item(CMD_NOTE, 1, 2, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 2, 1, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 3, 3, 1'b1), 0);
        drain();
        write_cap(1);
        send_item(make_item(CMD_NOTE, 4, 4, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 1, 2, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 2, 1, 1'b0), 0);
        send_item(make_item(CMD_NOTE, 3, 3, 1'b0), 0);
        drain();
        write_cap(0);
        send_item(make_item(CMD_NOTE, 7, 7, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 8, 8, 1'b1), 0);
        send_item(make_item(CMD_NOTE, 7, 7, 1'b0), 0);
        drain();

        write_cap(2);
        random_phase(80, 55, 1'b1);
        write_cap(1024);
        random_phase(100, 70, 1'b0);
        write_cap(2047);
        random_phase(90, 75, 1'b0);
        write_cap(5);
        random_phase(80, 30, 1'b0);
        write_cap(8);
        random_phase(100, 50, 1'b1);
        write_cap(1);
        random_phase(60, 50, 1'b1);

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d items and %0d results over %0d cap settings.",
                 sb.items, sb.results, cap_writes + 1);
        $display("Overflow records: %0d; highest active count: %0d.", sb.overflows, sb.peak);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
